// File: hw/rtl/hsr_pkg.sv
// Shared types and constants of the humidity sensor reader.
package hsr_pkg;

	localparam int READ_BYTES       = 6;
	localparam int WRITE_DATA_BYTES = 2;

	localparam int FRAC_BITS   = 20;
	localparam int TEMP_SCALE  = 20000;
	localparam int HUM_SCALE   = 10000;
	localparam int TEMP_OFFSET = 5000;

	localparam logic [7:0] CAL_DATA = 8'h08;

	localparam logic [1:0] ACT_INIT    = 2'd1;
	localparam logic [1:0] ACT_MEASURE = 2'd2;

	localparam logic [2:0] REG_DEVICE_ADDRESS    = 3'd0;
	localparam logic [2:0] REG_MEASURE_COMMAND   = 3'd1;
	localparam logic [2:0] REG_NORMAL_COMMAND    = 3'd2;
	localparam logic [2:0] REG_CALIBRATE_COMMAND = 3'd3;
	localparam logic [2:0] REG_ACK_TIMEOUT       = 3'd4;
	localparam logic [2:0] REG_INIT_WAIT_TICKS   = 3'd5;

	localparam logic [6:0]  RST_DEVICE_ADDRESS    = 7'd56;
	localparam logic [7:0]  RST_MEASURE_COMMAND   = 8'd172;
	localparam logic [7:0]  RST_NORMAL_COMMAND    = 8'd168;
	localparam logic [7:0]  RST_CALIBRATE_COMMAND = 8'd225;
	localparam logic [15:0] RST_ACK_TIMEOUT       = 16'd1000;
	localparam logic [23:0] RST_INIT_WAIT_TICKS   = 24'd300000;

	typedef enum logic [3:0] {
		ST_IDLE = 4'd0,
		ST_STA  = 4'd1,
		ST_STB  = 4'd2,
		ST_TXL  = 4'd3,
		ST_TXH  = 4'd4,
		ST_AKL  = 4'd5,
		ST_AKH  = 4'd6,
		ST_RXL  = 4'd7,
		ST_RXH  = 4'd8,
		ST_MKL  = 4'd9,
		ST_MKH  = 4'd10,
		ST_SPA  = 4'd11,
		ST_SPB  = 4'd12,
		ST_SPC  = 4'd13,
		ST_WAIT = 4'd14
	} step_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_INIT    = 2'd1,
		KIND_MEASURE = 2'd2
	} kind_t;

endpackage

// File: hw/rtl/hsr_in_if.sv
// Tick channel into the reader: action and sampled SDA level.
interface hsr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       sda_in;

	modport source(output valid, action, sda_in, input ready);
	modport sink(input valid, action, sda_in, output ready);
endinterface

// File: hw/rtl/hsr_out_if.sv
// Result channel of the reader: bus levels, status and last readings.
interface hsr_out_if;
	logic               valid;
	logic               ready;
	logic               scl;
	logic               sda_release;
	logic               busy_res;
	logic               done_res;
	logic               failed;
	logic signed [14:0] temperature_centi;
	logic        [13:0] humidity_centi;

	modport source(output valid, scl, sda_release, busy_res, done_res, failed,
		temperature_centi, humidity_centi, input ready);
	modport sink(input valid, scl, sda_release, busy_res, done_res, failed,
		temperature_centi, humidity_centi, output ready);
endinterface

// File: hw/rtl/i2c_humidity_sensor_reader_top.sv
// Tick-driven I2C master that initializes and reads a temperature/humidity sensor.
//
// in_ch carries one tick per item: an action (plain tick, start init, start
// measurement) and the SDA level sampled in that tick. Each tick is one half-bit
// phase of the bus. For every tick one item leaves on out_ch with the SCL/SDA
// levels to drive during that tick, busy, a one-tick done pulse, the failed flag
// and the last temperature and humidity in hundredths.
// The item passes an input register and a result register, and one tick is taken
// every cycle while out_ch is not stalled. The products of the conversion are
// formed in a register of their own ahead of the result stage, from bytes that
// settle before the stop.
// When out_ch is stalled the result register holds, the input register fills,
// and then in_ch.ready drops until the receiver takes the waiting item.
// Reset returns the sequencer to idle, clears readings and flags, and loads the
// default register values. Registers are written through the APB port at byte
// address 4*index and are meant to change only while no sequence runs.
module i2c_humidity_sensor_reader_top (
	input  logic        clk,
	input  logic        arst_n,
	hsr_in_if.sink      in_ch,
	hsr_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [6:0]  dev_addr_q;
	logic [7:0]  cmd_meas_q;
	logic [7:0]  cmd_norm_q;
	logic [7:0]  cmd_cal_q;
	logic [15:0] ack_timeout_q;
	logic [23:0] init_wait_q;

	// input stage
	logic       valid_s1;
	logic [1:0] action_s1;
	logic       sda_in_s1;
	logic       adv;

	// sequencer state
	hsr_pkg::step_t step_q, step_d;
	hsr_pkg::kind_t kind_q, kind_d;
	logic        leg_q, leg_d;
	logic [3:0]  bit_cnt_q, bit_cnt_d;
	logic [2:0]  byte_cnt_q, byte_cnt_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tmo_q, tmo_d;
	logic [23:0] wait_q, wait_d;
	logic        fail_q, fail_d;
	logic signed [14:0] temp_q, temp_d;
	logic [13:0] humid_q, humid_d;
	logic        scl_o, sda_o, done_o, finish;
	logic        rx_we;
	logic [2:0]  rx_idx;

	logic [7:0]  rxb_q [1:hsr_pkg::READ_BYTES-1];

	// conversion
	logic [19:0] t_raw, h_raw;
	logic [34:0] t_full;
	logic [33:0] h_full;
	logic [14:0] t_prod_q;
	logic [13:0] h_prod_q;

	// result stage
	logic               out_valid_q;
	logic               out_scl_q, out_sda_q, out_busy_q, out_done_q, out_fail_q;
	logic signed [14:0] out_temp_q;
	logic [13:0]        out_humid_q;

	function automatic logic [7:0] wr_byte(
		input hsr_pkg::kind_t kind,
		input logic           leg,
		input logic [2:0]     idx,
		input logic [6:0]     dev,
		input logic [7:0]     cmd_norm,
		input logic [7:0]     cmd_cal,
		input logic [7:0]     cmd_meas
	);
		logic [7:0] b;
		b = 8'd0;
		if (idx == 3'd0)
			b = {dev, 1'b0};
		else if (idx == 3'd1)
			b = (kind == hsr_pkg::KIND_INIT) ? (leg ? cmd_cal : cmd_norm) : cmd_meas;
		else if (kind == hsr_pkg::KIND_INIT && leg && idx == 3'd2)
			b = hsr_pkg::CAL_DATA;
		return b;
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= hsr_pkg::RST_DEVICE_ADDRESS;
			cmd_meas_q    <= hsr_pkg::RST_MEASURE_COMMAND;
			cmd_norm_q    <= hsr_pkg::RST_NORMAL_COMMAND;
			cmd_cal_q     <= hsr_pkg::RST_CALIBRATE_COMMAND;
			ack_timeout_q <= hsr_pkg::RST_ACK_TIMEOUT;
			init_wait_q   <= hsr_pkg::RST_INIT_WAIT_TICKS;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:2])
				hsr_pkg::REG_DEVICE_ADDRESS:    dev_addr_q    <= pwdata[6:0];
				hsr_pkg::REG_MEASURE_COMMAND:   cmd_meas_q    <= pwdata[7:0];
				hsr_pkg::REG_NORMAL_COMMAND:    cmd_norm_q    <= pwdata[7:0];
				hsr_pkg::REG_CALIBRATE_COMMAND: cmd_cal_q     <= pwdata[7:0];
				hsr_pkg::REG_ACK_TIMEOUT:       ack_timeout_q <= pwdata[15:0];
				hsr_pkg::REG_INIT_WAIT_TICKS:   init_wait_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			hsr_pkg::REG_DEVICE_ADDRESS:    prdata = {25'd0, dev_addr_q};
			hsr_pkg::REG_MEASURE_COMMAND:   prdata = {24'd0, cmd_meas_q};
			hsr_pkg::REG_NORMAL_COMMAND:    prdata = {24'd0, cmd_norm_q};
			hsr_pkg::REG_CALIBRATE_COMMAND: prdata = {24'd0, cmd_cal_q};
			hsr_pkg::REG_ACK_TIMEOUT:       prdata = {16'd0, ack_timeout_q};
			hsr_pkg::REG_INIT_WAIT_TICKS:   prdata = {8'd0, init_wait_q};
			default:                        prdata = 32'd0;
		endcase
	end

	// ---------------- input stage ----------------
	assign adv         = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.valid && in_ch.ready)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1 <= in_ch.action;
			sda_in_s1 <= in_ch.sda_in;
		end
	end

	// ---------------- conversion products ----------------
	assign t_raw  = {rxb_q[3][3:0], rxb_q[4], rxb_q[5]};
	assign h_raw  = {rxb_q[1], rxb_q[2], rxb_q[3][7:4]};
	assign t_full = 35'(t_raw) * 35'(hsr_pkg::TEMP_SCALE);
	assign h_full = 34'(h_raw) * 34'(hsr_pkg::HUM_SCALE);

	always_ff @(posedge clk) begin
		t_prod_q <= t_full[34:hsr_pkg::FRAC_BITS];
		h_prod_q <= h_full[33:hsr_pkg::FRAC_BITS];
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= hsr_pkg::ST_IDLE;
			kind_q     <= hsr_pkg::KIND_NONE;
			leg_q      <= 1'b0;
			bit_cnt_q  <= 4'd0;
			byte_cnt_q <= 3'd0;
			shift_q    <= 8'd0;
			tmo_q      <= 16'd0;
			wait_q     <= 24'd0;
			fail_q     <= 1'b0;
			temp_q     <= 15'sd0;
			humid_q    <= 14'd0;
		end else if (valid_s1 && adv) begin
			step_q     <= step_d;
			kind_q     <= kind_d;
			leg_q      <= leg_d;
			bit_cnt_q  <= bit_cnt_d;
			byte_cnt_q <= byte_cnt_d;
			shift_q    <= shift_d;
			tmo_q      <= tmo_d;
			wait_q     <= wait_d;
			fail_q     <= fail_d;
			temp_q     <= temp_d;
			humid_q    <= humid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && rx_we)
			rxb_q[rx_idx] <= shift_d;
	end

	always_comb begin
		logic [3:0]  bit_inc;
		logic [2:0]  byte_inc;
		logic [16:0] tmo_inc;
		logic [23:0] wait_inc;
		step_d     = step_q;
		kind_d     = kind_q;
		leg_d      = leg_q;
		bit_cnt_d  = bit_cnt_q;
		byte_cnt_d = byte_cnt_q;
		shift_d    = shift_q;
		tmo_d      = tmo_q;
		wait_d     = wait_q;
		fail_d     = fail_q;
		temp_d     = temp_q;
		humid_d    = humid_q;
		finish     = 1'b0;
		rx_we      = 1'b0;
		rx_idx     = byte_cnt_q - 3'd1;
		scl_o      = 1'b1;
		sda_o      = 1'b1;
		bit_inc    = bit_cnt_q + 4'd1;
		byte_inc   = byte_cnt_q + 3'd1;
		tmo_inc    = {1'b0, tmo_q} + 17'd1;
		wait_inc   = wait_q + 24'd1;

		case (step_q)
			hsr_pkg::ST_STB: sda_o = 1'b0;
			hsr_pkg::ST_TXL: begin
				scl_o = 1'b0;
				sda_o = shift_q[7];
			end
			hsr_pkg::ST_TXH: sda_o = shift_q[7];
			hsr_pkg::ST_AKL, hsr_pkg::ST_RXL: scl_o = 1'b0;
			hsr_pkg::ST_MKL: begin
				scl_o = 1'b0;
				sda_o = (byte_cnt_q >= 3'(hsr_pkg::READ_BYTES));
			end
			hsr_pkg::ST_MKH: sda_o = (byte_cnt_q >= 3'(hsr_pkg::READ_BYTES));
			hsr_pkg::ST_SPA: begin
				scl_o = 1'b0;
				sda_o = 1'b0;
			end
			hsr_pkg::ST_SPB: sda_o = 1'b0;
			default: ;
		endcase

		unique case (step_q)
			hsr_pkg::ST_IDLE: begin
				if (action_s1 == hsr_pkg::ACT_INIT || action_s1 == hsr_pkg::ACT_MEASURE) begin
					kind_d     = (action_s1 == hsr_pkg::ACT_INIT) ? hsr_pkg::KIND_INIT
						: hsr_pkg::KIND_MEASURE;
					fail_d     = 1'b0;
					bit_cnt_d  = 4'd0;
					byte_cnt_d = 3'd0;
					leg_d      = 1'b0;
					step_d     = hsr_pkg::ST_STA;
				end
			end
			hsr_pkg::ST_STA: step_d = hsr_pkg::ST_STB;
			hsr_pkg::ST_STB: begin
				byte_cnt_d = 3'd0;
				bit_cnt_d  = 4'd0;
				shift_d    = wr_byte(kind_q, leg_q, 3'd0, dev_addr_q, cmd_norm_q, cmd_cal_q,
					cmd_meas_q) | {7'd0, (kind_q == hsr_pkg::KIND_MEASURE && leg_q)};
				step_d     = hsr_pkg::ST_TXL;
			end
			hsr_pkg::ST_TXL: step_d = hsr_pkg::ST_TXH;
			hsr_pkg::ST_TXH: begin
				shift_d = {shift_q[6:0], 1'b0};
				if (bit_inc >= 4'd8) begin
					bit_cnt_d = 4'd0;
					step_d    = hsr_pkg::ST_AKL;
				end else begin
					bit_cnt_d = bit_inc;
					step_d    = hsr_pkg::ST_TXL;
				end
			end
			hsr_pkg::ST_AKL: begin
				tmo_d  = 16'd0;
				step_d = hsr_pkg::ST_AKH;
			end
			hsr_pkg::ST_AKH: begin
				if (!sda_in_s1) begin
					tmo_d      = 16'd0;
					byte_cnt_d = byte_inc;
					if (kind_q == hsr_pkg::KIND_MEASURE && leg_q) begin
						shift_d   = 8'd0;
						bit_cnt_d = 4'd0;
						step_d    = hsr_pkg::ST_RXL;
					end else if (byte_inc < 3'(2 + hsr_pkg::WRITE_DATA_BYTES)) begin
						shift_d = wr_byte(kind_q, leg_q, byte_inc, dev_addr_q, cmd_norm_q,
							cmd_cal_q, cmd_meas_q);
						step_d  = hsr_pkg::ST_TXL;
					end else begin
						step_d = hsr_pkg::ST_SPA;
					end
				end else if (tmo_inc >= {1'b0, ack_timeout_q}) begin
					tmo_d  = 16'd0;
					fail_d = 1'b1;
					step_d = hsr_pkg::ST_SPA;
				end else begin
					tmo_d = tmo_inc[15:0];
				end
			end
			hsr_pkg::ST_RXL: step_d = hsr_pkg::ST_RXH;
			hsr_pkg::ST_RXH: begin
				shift_d = {shift_q[6:0], sda_in_s1};
				if (bit_inc >= 4'd8) begin
					bit_cnt_d = 4'd0;
					// first read byte is status, only the data bytes are kept
					rx_we     = (byte_cnt_q >= 3'd2)
						&& (byte_cnt_q <= 3'(hsr_pkg::READ_BYTES));
					step_d    = hsr_pkg::ST_MKL;
				end else begin
					bit_cnt_d = bit_inc;
					step_d    = hsr_pkg::ST_RXL;
				end
			end
			hsr_pkg::ST_MKL: step_d = hsr_pkg::ST_MKH;
			hsr_pkg::ST_MKH: begin
				if (byte_cnt_q >= 3'(hsr_pkg::READ_BYTES)) begin
					step_d = hsr_pkg::ST_SPA;
				end else begin
					byte_cnt_d = byte_inc;
					shift_d    = 8'd0;
					step_d     = hsr_pkg::ST_RXL;
				end
			end
			hsr_pkg::ST_SPA: step_d = hsr_pkg::ST_SPB;
			hsr_pkg::ST_SPB: step_d = hsr_pkg::ST_SPC;
			hsr_pkg::ST_SPC: begin
				if (fail_q) begin
					finish = 1'b1;
				end else if (kind_q == hsr_pkg::KIND_INIT) begin
					if (init_wait_q != 24'd0) begin
						wait_d = 24'd0;
						step_d = hsr_pkg::ST_WAIT;
					end else if (!leg_q) begin
						leg_d  = 1'b1;
						step_d = hsr_pkg::ST_STA;
					end else begin
						finish = 1'b1;
					end
				end else if (kind_q == hsr_pkg::KIND_MEASURE && !leg_q) begin
					leg_d  = 1'b1;
					step_d = hsr_pkg::ST_STA;
				end else begin
					if (kind_q == hsr_pkg::KIND_MEASURE) begin
						temp_d  = 15'($signed({1'b0, t_prod_q}) - 16'sd5000);
						humid_d = h_prod_q;
					end
					finish = 1'b1;
				end
			end
			hsr_pkg::ST_WAIT: begin
				wait_d = wait_inc;
				if (wait_inc >= init_wait_q) begin
					if (!leg_q) begin
						leg_d  = 1'b1;
						step_d = hsr_pkg::ST_STA;
					end else begin
						finish = 1'b1;
					end
				end
			end
			default: finish = 1'b1;
		endcase

		if (finish) begin
			step_d = hsr_pkg::ST_IDLE;
			kind_d = hsr_pkg::KIND_NONE;
			leg_d  = 1'b0;
		end
		done_o = finish && (step_q != hsr_pkg::ST_IDLE);
	end

	// ---------------- result stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (valid_s1 && adv)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			out_scl_q   <= scl_o;
			out_sda_q   <= sda_o;
			out_busy_q  <= (step_d != hsr_pkg::ST_IDLE);
			out_done_q  <= done_o;
			out_fail_q  <= fail_d;
			out_temp_q  <= temp_d;
			out_humid_q <= humid_d;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.scl               = out_scl_q;
	assign out_ch.sda_release       = out_sda_q;
	assign out_ch.busy_res          = out_busy_q;
	assign out_ch.done_res          = out_done_q;
	assign out_ch.failed            = out_fail_q;
	assign out_ch.temperature_centi = out_temp_q;
	assign out_ch.humidity_centi    = out_humid_q;

	// ---------------- assertions ----------------
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == hsr_pkg::ST_IDLE |-> kind_q == hsr_pkg::KIND_NONE && !leg_q)
		else $error("idle sequencer holds a sequence kind or leg");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < 4'd8 && byte_cnt_q <= 3'(hsr_pkg::READ_BYTES))
		else $error("bit or byte count out of range");

	a_fail_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fail_q) |-> $past(step_q) == hsr_pkg::ST_AKH)
		else $error("failed set outside an acknowledge wait");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && done_o |=> step_q == hsr_pkg::ST_IDLE && !out_busy_q && out_done_q)
		else $error("done without return to idle");

endmodule
